@@ rtl/stt_pkg.sv @@
// Shared constants, codes and control structs of the software timer table.
// Used by the controller, the datapath and the top level.
`default_nettype none
package stt_pkg;
	localparam int MAX_TIMERS = 16;
	localparam int IDX_W = $clog2(MAX_TIMERS);
	localparam int TIME_W = 48;
	localparam int DLY_W = 40;
	localparam int TAG_W = 32;
	localparam int ORD_W = 32;
	localparam int ID_W = 6;
	localparam int CNT_W = 6;
	localparam int STAT_W = 3;

	typedef enum logic [1:0] {
		CMD_REL = 2'd0,
		CMD_ABS = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SCHED = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_EXPIRY = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 3'd0,
		ST_DELAY = 3'd1,
		ST_FULL = 3'd2,
		ST_BAD_ID = 3'd3,
		ST_INACTIVE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OSEL_REPLY = 2'd0,
		OSEL_SCHED_OK = 2'd1,
		OSEL_EXPIRY = 2'd2,
		OSEL_DONE = 2'd3
	} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_REPLY_OK,
		S_REPLY,
		S_DUE_SCAN,
		S_DUE_END,
		S_SEL_SCAN,
		S_PICK
	} state_t;

	typedef struct packed {
		logic load;
		logic alloc_init;
		logic alloc_step;
		logic alloc_commit;
		logic due_init;
		logic due_step;
		logic final_load;
		logic sel_init;
		logic sel_step;
		logic fire;
		logic out_load;
		out_sel_t out_sel;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic delay_bad;
		logic full;
		logic idx_free;
		logic idx_last;
		logic found;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

@@ rtl/stt_ctrl.sv @@
// Controller state machine of the timer table: sequences allocation, tick scans
// and result words. Depends on stt_pkg and drives stt_dp through ctl_cmd_t.
`default_nettype none
module stt_ctrl import stt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input dp_stat_t stat,
	output ctl_cmd_t ctl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_REL, CMD_ABS: begin
						if ((stat.cmd == CMD_REL && stat.delay_bad) || stat.full) begin
							state_d = S_REPLY;
						end else begin
							ctl.alloc_init = 1'b1;
							state_d = S_SEARCH;
						end
					end
					CMD_CANCEL: state_d = S_REPLY;
					default: begin
						ctl.due_init = 1'b1;
						state_d = S_DUE_SCAN;
					end
				endcase
			end
			S_SEARCH: begin
				if (stat.idx_free) begin
					ctl.alloc_commit = 1'b1;
					state_d = S_REPLY_OK;
				end else begin
					ctl.alloc_step = 1'b1;
				end
			end
			S_REPLY_OK: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_sel = OSEL_SCHED_OK;
					state_d = S_IDLE;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_sel = OSEL_REPLY;
					state_d = S_IDLE;
				end
			end
			S_DUE_SCAN: begin
				ctl.due_step = 1'b1;
				if (stat.idx_last) begin
					state_d = S_DUE_END;
				end
			end
			S_DUE_END: begin
				ctl.final_load = 1'b1;
				ctl.sel_init = 1'b1;
				state_d = S_SEL_SCAN;
			end
			S_SEL_SCAN: begin
				ctl.sel_step = 1'b1;
				if (stat.idx_last) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					if (stat.found) begin
						ctl.out_sel = OSEL_EXPIRY;
						ctl.fire = 1'b1;
						ctl.sel_init = 1'b1;
						state_d = S_SEL_SCAN;
					end else begin
						ctl.out_sel = OSEL_DONE;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/stt_dp.sv @@
// Datapath of the timer table: entry registers, scan index, best-entry tracking
// and the output register. Depends on stt_pkg; commanded by stt_ctrl.
`default_nettype none
module stt_dp import stt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input ctl_cmd_t ctl,
	output dp_stat_t stat,
	input wire logic cfg_valid,
	input wire logic [DLY_W-1:0] max_delay,
	input wire logic [1:0] command,
	input wire logic [TIME_W-1:0] now_time,
	input wire logic [DLY_W-1:0] delay,
	input wire logic [TIME_W-1:0] expiry_time,
	input wire logic recurring,
	input wire logic [ID_W-1:0] cancel_id,
	input wire logic [TAG_W-1:0] user_tag,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0] result_id,
	output logic [TAG_W-1:0] tag_out,
	output logic [CNT_W-1:0] active_count,
	output logic last
);
	logic [DLY_W-1:0] max_delay_q;
	cmd_t cmd_q;
	logic [TIME_W-1:0] now_q, abs_q;
	logic [DLY_W-1:0] delay_q;
	logic rec_q;
	logic [ID_W-1:0] cid_q;
	logic [TAG_W-1:0] tag_q;

	logic [MAX_TIMERS-1:0] valid_q, due_q;
	logic [TIME_W-1:0] exp_q [MAX_TIMERS];
	logic [DLY_W-1:0] per_q [MAX_TIMERS];
	logic rep_q [MAX_TIMERS];
	logic [ORD_W-1:0] ord_q [MAX_TIMERS];
	logic [TAG_W-1:0] etag_q [MAX_TIMERS];

	logic [ID_W-1:0] last_id_q;
	logic [CNT_W-1:0] active_q, final_q, drop_q;
	logic [ORD_W-1:0] order_cnt_q;
	logic [IDX_W-1:0] idx_q, best_q;
	logic found_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [ORD_W-1:0] best_ord_q;
	logic [DLY_W-1:0] best_per_q;
	logic best_rep_q;
	logic [TAG_W-1:0] best_tag_q;

	logic [IDX_W-1:0] idx_next;
	logic cid_bad, cid_on, cancel_ok, is_due, better;
	logic [TIME_W:0] sum_new, sum_rearm;
	logic [TIME_W-1:0] exp_new, exp_rearm;
	status_t reply_status;

	always_comb begin
		idx_next = (idx_q == IDX_W'(MAX_TIMERS - 1)) ? '0 : idx_q + 1'b1;
		cid_bad = cid_q >= ID_W'(MAX_TIMERS);
		cid_on = !cid_bad && valid_q[cid_q[IDX_W-1:0]];
		cancel_ok = (cmd_q == CMD_CANCEL) && cid_on;
		sum_new = {1'b0, now_q} + {{(TIME_W + 1 - DLY_W){1'b0}}, delay_q};
		exp_new = sum_new[TIME_W] ? '1 : sum_new[TIME_W-1:0];
		sum_rearm = {1'b0, now_q} + {{(TIME_W + 1 - DLY_W){1'b0}}, best_per_q};
		exp_rearm = sum_rearm[TIME_W] ? '1 : sum_rearm[TIME_W-1:0];
		is_due = valid_q[idx_q] && (exp_q[idx_q] <= now_q);
		better = due_q[idx_q] && (!found_q || exp_q[idx_q] < best_exp_q ||
			(exp_q[idx_q] == best_exp_q && ord_q[idx_q] < best_ord_q));
		if (cmd_q == CMD_CANCEL) begin
			reply_status = cid_bad ? ST_BAD_ID : (cid_on ? ST_OK : ST_INACTIVE);
		end else begin
			reply_status = (cmd_q == CMD_REL && delay_q > max_delay_q) ? ST_DELAY : ST_FULL;
		end
		stat.cmd = cmd_q;
		stat.delay_bad = delay_q > max_delay_q;
		stat.full = active_q >= CNT_W'(MAX_TIMERS);
		stat.idx_free = !valid_q[idx_q];
		stat.idx_last = idx_q == IDX_W'(MAX_TIMERS - 1);
		stat.found = found_q;
		stat.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q <= '1;
			valid_q <= '0;
			last_id_q <= '0;
			active_q <= '0;
			order_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_delay_q <= max_delay;
			end
			if (ctl.alloc_commit) begin
				valid_q[idx_q] <= 1'b1;
				last_id_q <= ID_W'(idx_q);
				active_q <= active_q + 1'b1;
				order_cnt_q <= order_cnt_q + 1'b1;
			end
			if (ctl.out_load && ctl.out_sel == OSEL_REPLY && cancel_ok) begin
				valid_q[cid_q[IDX_W-1:0]] <= 1'b0;
				active_q <= active_q - 1'b1;
			end
			if (ctl.fire) begin
				if (best_rep_q) begin
					order_cnt_q <= order_cnt_q + 1'b1;
				end else begin
					valid_q[best_q] <= 1'b0;
					active_q <= active_q - 1'b1;
				end
			end
			if (ctl.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(command);
			now_q <= now_time;
			delay_q <= delay;
			abs_q <= expiry_time;
			rec_q <= recurring;
			cid_q <= cancel_id;
			tag_q <= user_tag;
		end
		if (ctl.alloc_init) begin
			idx_q <= (last_id_q >= ID_W'(MAX_TIMERS - 1)) ? '0 : last_id_q[IDX_W-1:0] + 1'b1;
		end
		if (ctl.alloc_step || ctl.due_step || ctl.sel_step) begin
			idx_q <= idx_next;
		end
		if (ctl.due_init || ctl.sel_init) begin
			idx_q <= '0;
		end
		if (ctl.alloc_commit) begin
			if (cmd_q == CMD_REL) begin
				exp_q[idx_q] <= exp_new;
				per_q[idx_q] <= delay_q;
				rep_q[idx_q] <= rec_q;
			end else begin
				exp_q[idx_q] <= abs_q;
				per_q[idx_q] <= '0;
				rep_q[idx_q] <= 1'b0;
			end
			ord_q[idx_q] <= order_cnt_q;
			etag_q[idx_q] <= tag_q;
		end
		if (ctl.due_init) begin
			drop_q <= '0;
		end
		if (ctl.due_step) begin
			due_q[idx_q] <= is_due;
			if (is_due && !rep_q[idx_q]) begin
				drop_q <= drop_q + 1'b1;
			end
		end
		if (ctl.final_load) begin
			final_q <= active_q - drop_q;
		end
		if (ctl.sel_init) begin
			found_q <= 1'b0;
		end
		if (ctl.sel_step && better) begin
			found_q <= 1'b1;
			best_q <= idx_q;
			best_exp_q <= exp_q[idx_q];
			best_ord_q <= ord_q[idx_q];
			best_per_q <= per_q[idx_q];
			best_rep_q <= rep_q[idx_q];
			best_tag_q <= etag_q[idx_q];
		end
		if (ctl.fire) begin
			due_q[best_q] <= 1'b0;
			if (best_rep_q) begin
				exp_q[best_q] <= exp_rearm;
				ord_q[best_q] <= order_cnt_q;
			end
		end
		if (ctl.out_load) begin
			case (ctl.out_sel)
				OSEL_REPLY: begin
					kind <= (cmd_q == CMD_CANCEL) ? KIND_CANCEL : KIND_SCHED;
					status <= reply_status;
					result_id <= (cmd_q == CMD_CANCEL) ? cid_q : '0;
					tag_out <= '0;
					active_count <= cancel_ok ? active_q - 1'b1 : active_q;
					last <= 1'b1;
				end
				OSEL_SCHED_OK: begin
					kind <= KIND_SCHED;
					status <= ST_OK;
					result_id <= last_id_q;
					tag_out <= '0;
					active_count <= active_q;
					last <= 1'b1;
				end
				OSEL_EXPIRY: begin
					kind <= KIND_EXPIRY;
					status <= ST_OK;
					result_id <= ID_W'(best_q);
					tag_out <= best_tag_q;
					active_count <= final_q;
					last <= 1'b0;
				end
				default: begin
					kind <= KIND_DONE;
					status <= ST_OK;
					result_id <= '0;
					tag_out <= '0;
					active_count <= final_q;
					last <= 1'b1;
				end
			endcase
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(active_q)) else $error("active count mismatch");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= CNT_W'(MAX_TIMERS)) else $error("active count above table size");
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire |-> due_q[best_q] && valid_q[best_q]) else $error("fired entry not due");
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc_commit |=> valid_q[last_id_q[IDX_W-1:0]]) else $error("allocation lost");
endmodule
`default_nettype wire

@@ rtl/software_timer_table_core.sv @@
// A schedule makes a next-fit walk of the table, one entry a cycle; a refused schedule
// or a cancel is answered without a walk.
// A tick first runs the due scan; then, for each expiry word and for the tick-done word,
// a pick rescans all 16 entries with one comparator.
// One item is in work at a time; the next is taken once the last word is registered.
// Reset (arst_n low) clears all timers, the active and order counters, the last
// allocated id and out_valid; max_delay returns to all ones.
`default_nettype none
module software_timer_table_core import stt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [DLY_W-1:0] max_delay,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] command,
	input wire logic [TIME_W-1:0] now_time,
	input wire logic [DLY_W-1:0] delay,
	input wire logic [TIME_W-1:0] expiry_time,
	input wire logic recurring,
	input wire logic [ID_W-1:0] cancel_id,
	input wire logic [TAG_W-1:0] user_tag,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0] result_id,
	output logic [TAG_W-1:0] tag_out,
	output logic [CNT_W-1:0] active_count,
	output logic last
);
	ctl_cmd_t ctl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	stt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat(stat),
		.ctl(ctl)
	);

	stt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.stat(stat),
		.cfg_valid(cfg_valid),
		.max_delay(max_delay),
		.command(command),
		.now_time(now_time),
		.delay(delay),
		.expiry_time(expiry_time),
		.recurring(recurring),
		.cancel_id(cancel_id),
		.user_tag(user_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.status(status),
		.result_id(result_id),
		.tag_out(tag_out),
		.active_count(active_count),
		.last(last)
	);
endmodule
`default_nettype wire
